// ===== rtl/mdcr_pkg.sv =====
// Shared types, constants and the arctangent table for the mouse delta camera rotator.
// No dependencies; every other file of the block refers to it by scoped names.
package mdcr_pkg;

   // Defaults for the top-level parameters
   localparam int ANGLE_BITS_DEF    = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   // Component and working widths
   localparam int COMP_W     = 16;
   localparam int GUARD_BITS = 8;
   localparam int WORK_W     = COMP_W + GUARD_BITS + 3;
   localparam int Z_W        = 33;
   localparam int PROD_W     = WORK_W + 33;

   // Inverse CORDIC gain, unsigned Q0.32
   localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

   // Register reset values
   localparam logic [15:0] SENS_RST    = 16'd8011;
   localparam logic [15:0] DIR_X_RST   = 16'h0000;
   localparam logic [15:0] DIR_Y_RST   = 16'hC000;
   localparam logic [15:0] PLANE_X_RST = 16'd10813;
   localparam logic [15:0] PLANE_Y_RST = 16'h0000;

   // Register indexes
   localparam logic [2:0] REG_SENS    = 3'd0;
   localparam logic [2:0] REG_DIR_X   = 3'd1;
   localparam logic [2:0] REG_DIR_Y   = 3'd2;
   localparam logic [2:0] REG_PLANE_X = 3'd3;
   localparam logic [2:0] REG_PLANE_Y = 3'd4;

   // Component slots in the datapath
   localparam logic [1:0] COMP_DIR_X   = 2'd0;
   localparam logic [1:0] COMP_DIR_Y   = 2'd1;
   localparam logic [1:0] COMP_PLANE_X = 2'd2;
   localparam logic [1:0] COMP_PLANE_Y = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ANGLE = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_ITER  = 7'b0001000,
      ST_GMUL  = 7'b0010000,
      ST_GWR   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       angle;
      logic       load;
      logic       iter;
      logic [4:0] stage;
      logic       gmul;
      logic       gwr;
      logic [1:0] comp;
      logic       publish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic ang_zero;
   } status_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         5'd31: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/mdcr_datapath.sv =====
// Datapath: delta angle multiply, angle fold, two-lane iterative CORDIC, gain multiply.
// Holds the vector state and the result register. Depends on mdcr_pkg.
module mdcr_datapath #(
   parameter int ANGLE_BITS = mdcr_pkg::ANGLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mdcr_pkg::cmd_type         cmd,
   output mdcr_pkg::status_type      status,
   input  logic signed [15:0]        req_pointer_x,
   input  logic [15:0]               sensitivity,
   input  logic [3:0]                cfg_load,
   input  logic [15:0]               cfg_data,
   output logic signed [15:0]        rsp_view_dir_x,
   output logic signed [15:0]        rsp_view_dir_y,
   output logic signed [15:0]        rsp_cam_plane_x,
   output logic signed [15:0]        rsp_cam_plane_y
);

   localparam int WW = mdcr_pkg::WORK_W;
   localparam int PW = mdcr_pkg::PROD_W;
   localparam int GB = mdcr_pkg::GUARD_BITS;
   localparam logic signed [32:0] QUARTER = 33'sd1073741824;
   localparam logic signed [32:0] HALF    = 33'sd2147483648;

   logic signed [15:0]         px_ff, prev_ff;
   logic [ANGLE_BITS-1:0]      ang_ff;
   logic signed [32:0]         z_ff;
   logic signed [WW-1:0]       work_ff [4];
   logic signed [15:0]         vec_ff [4];
   logic signed [PW-1:0]       prod_ff;

   // Angle from pointer delta
   logic signed [16:0] delta;
   logic signed [33:0] ang_prod;
   assign delta    = 17'(px_ff) - 17'(prev_ff);
   assign ang_prod = delta * $signed({1'b0, sensitivity});

   // Left-align and fold into plus or minus a quarter turn
   logic [31:0]        a32;
   logic signed [32:0] zs, z_fold;
   logic               flip;
   always_comb begin
      a32  = 32'(ang_ff) << (32 - ANGLE_BITS);
      zs   = 33'($signed(a32));
      flip = (zs > QUARTER) || (zs < -QUARTER);
      if (!flip) begin
         z_fold = zs;
      end else if (zs > 33'sd0) begin
         z_fold = zs - HALF;
      end else begin
         z_fold = zs + HALF;
      end
   end

   // One CORDIC micro-rotation on both lanes
   logic signed [WW-1:0] work_in [4];
   logic signed [32:0]   z_in;
   logic signed [32:0]   atan_z;
   assign atan_z = 33'(mdcr_pkg::atan_turn(cmd.stage));
   always_comb begin
      if (z_ff >= 33'sd0) begin
         work_in[0] = work_ff[0] - (work_ff[1] >>> cmd.stage);
         work_in[1] = work_ff[1] + (work_ff[0] >>> cmd.stage);
         work_in[2] = work_ff[2] - (work_ff[3] >>> cmd.stage);
         work_in[3] = work_ff[3] + (work_ff[2] >>> cmd.stage);
         z_in       = z_ff - atan_z;
      end else begin
         work_in[0] = work_ff[0] + (work_ff[1] >>> cmd.stage);
         work_in[1] = work_ff[1] - (work_ff[0] >>> cmd.stage);
         work_in[2] = work_ff[2] + (work_ff[3] >>> cmd.stage);
         work_in[3] = work_ff[3] - (work_ff[2] >>> cmd.stage);
         z_in       = z_ff + atan_z;
      end
   end

   // Gain compensation, round half up, saturate
   logic signed [PW-1:0] prod_in, rounded, shifted;
   logic signed [15:0]   sat_val;
   assign prod_in = work_ff[cmd.comp] * $signed({1'b0, mdcr_pkg::INV_GAIN});
   always_comb begin
      rounded = prod_ff + (PW'(1) <<< (31 + GB));
      shifted = rounded >>> (32 + GB);
      if (shifted > PW'(32767)) begin
         sat_val = 16'sh7FFF;
      end else if (shifted < -PW'(32768)) begin
         sat_val = 16'sh8000;
      end else begin
         sat_val = shifted[15:0];
      end
   end

   // Capture, angle and CORDIC working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (cmd.angle) begin
         prev_ff <= px_ff;
      end
      if (cmd.capture) begin
         px_ff <= req_pointer_x;
      end
      if (cmd.angle) begin
         ang_ff <= ang_prod[ANGLE_BITS-1:0];
      end
      if (cmd.load) begin
         z_ff <= z_fold;
         for (int k = 0; k < 4; k++) begin
            work_ff[k] <= flip ? -(WW'(vec_ff[k]) <<< GB) : (WW'(vec_ff[k]) <<< GB);
         end
      end else if (cmd.iter) begin
         z_ff <= z_in;
         for (int k = 0; k < 4; k++) begin
            work_ff[k] <= work_in[k];
         end
      end
      if (cmd.gmul) begin
         prod_ff <= prod_in;
      end
   end

   // Vector state: start registers at reset and on writes, rotated values after gain
   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff[mdcr_pkg::COMP_DIR_X]   <= mdcr_pkg::DIR_X_RST;
         vec_ff[mdcr_pkg::COMP_DIR_Y]   <= mdcr_pkg::DIR_Y_RST;
         vec_ff[mdcr_pkg::COMP_PLANE_X] <= mdcr_pkg::PLANE_X_RST;
         vec_ff[mdcr_pkg::COMP_PLANE_Y] <= mdcr_pkg::PLANE_Y_RST;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (cfg_load[k]) begin
               vec_ff[k] <= cfg_data;
            end else if (cmd.gwr && (cmd.comp == 2'(k))) begin
               vec_ff[k] <= sat_val;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_view_dir_x  <= vec_ff[mdcr_pkg::COMP_DIR_X];
         rsp_view_dir_y  <= vec_ff[mdcr_pkg::COMP_DIR_Y];
         rsp_cam_plane_x <= vec_ff[mdcr_pkg::COMP_PLANE_X];
         rsp_cam_plane_y <= vec_ff[mdcr_pkg::COMP_PLANE_Y];
      end
   end

   assign status.ang_zero = (ang_ff == '0);

endmodule

// ===== rtl/mdcr_ctrl.sv =====
// Controller: sequences capture, angle, CORDIC iterations, gain and result hand-off.
// Owns the handshakes and the first-event flag. Depends on mdcr_pkg.
module mdcr_ctrl #(
   parameter int CORDIC_STAGES = mdcr_pkg::CORDIC_STAGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mdcr_pkg::cmd_type    cmd,
   input  mdcr_pkg::status_type status
);

   localparam int STAGE_W = $clog2(CORDIC_STAGES);
   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(CORDIC_STAGES - 1);

   mdcr_pkg::state_type state_ff, state_in;
   logic [STAGE_W-1:0]  stage_ff, stage_in;
   logic [1:0]          comp_ff, comp_in;
   logic                first_ff, first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mdcr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      comp_in      = comp_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.stage    = 5'(stage_ff);
      cmd.comp     = comp_ff;
      unique case (state_ff)
         mdcr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mdcr_pkg::ST_ANGLE;
            end
         end
         mdcr_pkg::ST_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = mdcr_pkg::ST_LOAD;
         end
         mdcr_pkg::ST_LOAD: begin
            first_in = 1'b0;
            if (first_ff || status.ang_zero) begin
               state_in = mdcr_pkg::ST_DONE;
            end else begin
               cmd.load = 1'b1;
               stage_in = '0;
               state_in = mdcr_pkg::ST_ITER;
            end
         end
         mdcr_pkg::ST_ITER: begin
            cmd.iter = 1'b1;
            if (stage_ff == LAST_STAGE) begin
               comp_in  = mdcr_pkg::COMP_DIR_X;
               state_in = mdcr_pkg::ST_GMUL;
            end else begin
               stage_in = stage_ff + STAGE_W'(1);
            end
         end
         mdcr_pkg::ST_GMUL: begin
            cmd.gmul = 1'b1;
            state_in = mdcr_pkg::ST_GWR;
         end
         mdcr_pkg::ST_GWR: begin
            cmd.gwr = 1'b1;
            if (comp_ff == mdcr_pkg::COMP_PLANE_Y) begin
               state_in = mdcr_pkg::ST_DONE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = mdcr_pkg::ST_GMUL;
            end
         end
         mdcr_pkg::ST_DONE: begin
            // hold until the result register is free
            if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mdcr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdcr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdcr_pkg::ST_IDLE;
         stage_ff     <= '0;
         comp_ff      <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         comp_ff      <= comp_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted beat starts the angle step
   a_accept_to_angle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == mdcr_pkg::ST_ANGLE))
      else $error("accepted beat did not start the angle step");

   // A result never overwrites one that is still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result published over a waiting beat");

   // The first event never rotates
   a_first_no_rotate: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !first_ff)
      else $error("rotation started on the first event");

   // The iteration loop leaves only after the last stage
   a_iter_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mdcr_pkg::ST_ITER && state_in != mdcr_pkg::ST_ITER)
         |-> (stage_ff == LAST_STAGE))
      else $error("CORDIC loop left early");

endmodule

// ===== rtl/mouse_delta_camera_rotator.sv =====
// Mouse delta camera rotator: takes one horizontal pointer position per beat and returns the
// view direction and camera plane vectors (Q2.14) after rotating both by delta times
// sensitivity. The first beat after reset only records the position. An event that rotates
// is done, and the next beat can be accepted, only once the iterative CORDIC (16 stages by
// default) that runs one micro-rotation per cycle and a single gain multiplier used once per
// component have finished; the first event and an event whose angle wraps to zero skip both.
// A finished result waits in its own register, so the next beat is accepted while it is still
// pending. Registers at byte addresses 0..16: sensitivity, start_dir_x, start_dir_y,
// start_plane_x, start_plane_y; writing a start register also loads that vector component
// at once. Write registers only while idle.
// Depends on mdcr_pkg, mdcr_ctrl and mdcr_datapath.
module mouse_delta_camera_rotator #(
   parameter int ANGLE_BITS    = mdcr_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = mdcr_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_pointer_x,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_view_dir_x,
   output logic signed [15:0] rsp_view_dir_y,
   output logic signed [15:0] rsp_cam_plane_x,
   output logic signed [15:0] rsp_cam_plane_y,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [15:0] sens_ff, dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;
   logic [3:0]  cfg_load;

   mdcr_pkg::cmd_type    cmd;
   mdcr_pkg::status_type status;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[4:2];

   // Load strobes for the vector state
   always_comb begin
      cfg_load = '0;
      if (wr_en) begin
         cfg_load[mdcr_pkg::COMP_DIR_X]   = (reg_idx == mdcr_pkg::REG_DIR_X);
         cfg_load[mdcr_pkg::COMP_DIR_Y]   = (reg_idx == mdcr_pkg::REG_DIR_Y);
         cfg_load[mdcr_pkg::COMP_PLANE_X] = (reg_idx == mdcr_pkg::REG_PLANE_X);
         cfg_load[mdcr_pkg::COMP_PLANE_Y] = (reg_idx == mdcr_pkg::REG_PLANE_Y);
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff    <= mdcr_pkg::SENS_RST;
         dir_x_ff   <= mdcr_pkg::DIR_X_RST;
         dir_y_ff   <= mdcr_pkg::DIR_Y_RST;
         plane_x_ff <= mdcr_pkg::PLANE_X_RST;
         plane_y_ff <= mdcr_pkg::PLANE_Y_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            mdcr_pkg::REG_SENS:    sens_ff    <= pwdata[15:0];
            mdcr_pkg::REG_DIR_X:   dir_x_ff   <= pwdata[15:0];
            mdcr_pkg::REG_DIR_Y:   dir_y_ff   <= pwdata[15:0];
            mdcr_pkg::REG_PLANE_X: plane_x_ff <= pwdata[15:0];
            mdcr_pkg::REG_PLANE_Y: plane_y_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back, start registers sign-extended
   always_comb begin
      unique case (reg_idx)
         mdcr_pkg::REG_SENS:    prdata = {16'h0000, sens_ff};
         mdcr_pkg::REG_DIR_X:   prdata = {{16{dir_x_ff[15]}}, dir_x_ff};
         mdcr_pkg::REG_DIR_Y:   prdata = {{16{dir_y_ff[15]}}, dir_y_ff};
         mdcr_pkg::REG_PLANE_X: prdata = {{16{plane_x_ff[15]}}, plane_x_ff};
         mdcr_pkg::REG_PLANE_Y: prdata = {{16{plane_y_ff[15]}}, plane_y_ff};
         default:               prdata = '0;
      endcase
   end

   mdcr_ctrl #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mdcr_datapath #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pointer_x   (req_pointer_x),
      .sensitivity     (sens_ff),
      .cfg_load        (cfg_load),
      .cfg_data        (pwdata[15:0]),
      .rsp_view_dir_x  (rsp_view_dir_x),
      .rsp_view_dir_y  (rsp_view_dir_y),
      .rsp_cam_plane_x (rsp_cam_plane_x),
      .rsp_cam_plane_y (rsp_cam_plane_y)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for mouse_delta_camera_rotator: drives pointer beats and CSR writes, predicts the
// rotated view and plane vectors with a local CORDIC model and checks every result beat.
// Depends on mdcr_pkg (register indexes) and the rotator RTL.
module tb;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } vec2_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
   } view_type;

   localparam int          STAGES      = 16;
   localparam longint      INV_K       = 64'sd2608131496;
   localparam longint      ROUND_HALF  = 64'sd1 <<< 39;
   localparam longint      QUARTER     = 64'sd1 <<< 30;
   localparam longint      HALF_TURN   = 64'sd1 <<< 31;
   localparam longint      FULL_TURN   = 64'sd1 <<< 32;
   localparam int          HOLD_CYCLES = 400;
   localparam int          IDLE_LIMIT  = 2000;
   localparam int          SETTLE      = 32;
   localparam logic [2:0]  REG_UNUSED  = 3'd7;

   // arctangent of 2^-i in 2^-32 turn units
   localparam logic [31:0] ATAN_TURN [0:STAGES-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_pointer_x   = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic signed [15:0] rsp_view_dir_x;
   logic signed [15:0] rsp_view_dir_y;
   logic signed [15:0] rsp_cam_plane_x;
   logic signed [15:0] rsp_cam_plane_y;
   logic               psel            = 1'b0;
   logic               penable         = 1'b0;
   logic               pwrite          = 1'b0;
   logic [4:0]         paddr           = '0;
   logic [31:0]        pwdata          = '0;
   logic [31:0]        prdata;
   logic               pready;

   // camera state as the block should hold it
   logic [15:0]        cam_sens;
   logic signed [15:0] cam_last_x;
   bit                 cam_first_pending;
   vec2_type           cam_dir;
   vec2_type           cam_plane;

   view_type           view_q [$];
   int                 errors       = 0;
   logic signed [15:0] sent_x       = '0;
   bit                 gaps_on      = 1'b1;
   bit                 sink_calm    = 1'b0;
   int                 hold_asked   = 0;
   int                 hold_taken   = 0;
   int unsigned        sink_stall   = 0;
   int unsigned        idle_cycles  = 0;

   mouse_delta_camera_rotator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pointer_x   (req_pointer_x),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_view_dir_x  (rsp_view_dir_x),
      .rsp_view_dir_y  (rsp_view_dir_y),
      .rsp_cam_plane_x (rsp_cam_plane_x),
      .rsp_cam_plane_y (rsp_cam_plane_y),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // rotate one vector by z (2^-32 turn, folded into +-1/4 turn), then undo the gain
   function automatic vec2_type turn_vector(vec2_type v, longint z, bit flip);
      longint   x, y, dx, dy;
      vec2_type r;
      x = v.x;
      y = v.y;
      x = x * 256;
      y = y * 256;
      if (flip) begin
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TURN[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TURN[i]);
         end
      end
      r.x = clamp16((x * INV_K + ROUND_HALF) >>> 40);
      r.y = clamp16((y * INV_K + ROUND_HALF) >>> 40);
      return r;
   endfunction

   // advance the camera state by one pointer beat and queue the view it yields
   task automatic predict_view(logic signed [15:0] px);
      longint      delta, prod, z;
      logic [23:0] ang;
      logic [31:0] a32;
      bit          flip;
      view_type    v;
      if (cam_first_pending) begin
         cam_first_pending = 1'b0;
      end else begin
         delta = longint'(px) - longint'(cam_last_x);
         prod  = delta * longint'(cam_sens);
         ang   = prod[23:0];
         // a wrapped angle of zero leaves both vectors untouched
         if (ang != 0) begin
            a32  = {ang, 8'h00};
            z    = longint'(a32);
            flip = 1'b0;
            if (z >= HALF_TURN) z = z - FULL_TURN;
            if (z > QUARTER) begin
               z    = z - HALF_TURN;
               flip = 1'b1;
            end else if (z < -QUARTER) begin
               z    = z + HALF_TURN;
               flip = 1'b1;
            end
            cam_dir   = turn_vector(cam_dir, z, flip);
            cam_plane = turn_vector(cam_plane, z, flip);
         end
      end
      cam_last_x = px;
      v.dir_x   = cam_dir.x;
      v.dir_y   = cam_dir.y;
      v.plane_x = cam_plane.x;
      v.plane_y = cam_plane.y;
      view_q.push_back(v);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_check
      view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (view_q.size() == 0) begin
            $error("result beat with no view expected");
            errors++;
         end else begin
            want = view_q.pop_front();
            check_field("view_dir_x", want.dir_x, rsp_view_dir_x);
            check_field("view_dir_y", want.dir_y, rsp_view_dir_y);
            check_field("cam_plane_x", want.plane_x, rsp_cam_plane_x);
            check_field("cam_plane_y", want.plane_y, rsp_cam_plane_y);
         end
      end
   end

   // ---------------------------------------------------------------- result sink

   // drop ready in random bursts; hold it low for a long stretch on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         sink_stall <= 0;
         hold_taken <= 0;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         sink_stall <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (sink_stall != 0) begin
         sink_stall <= sink_stall - 1;
         rsp_ready  <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
         sink_stall <= $urandom_range(1, 10) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // offer one pointer beat and hold it until accepted; valid stays high afterwards
   task automatic send_pointer(logic signed [15:0] px);
      req_valid     <= 1'b1;
      req_pointer_x <= px;
      do @(posedge clock); while (!req_ready);
      sent_x = px;
      predict_view(px);
   endtask

   // drop valid for a random burst now and then
   task automatic pointer_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // hold off the sender until every view has come back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (view_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write one register: setup phase, access phase, then an idle phase
   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         mdcr_pkg::REG_SENS:    cam_sens    = val;
         mdcr_pkg::REG_DIR_X:   cam_dir.x   = val;
         mdcr_pkg::REG_DIR_Y:   cam_dir.y   = val;
         mdcr_pkg::REG_PLANE_X: cam_plane.x = val;
         mdcr_pkg::REG_PLANE_Y: cam_plane.y = val;
         default:     ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_vectors(logic [15:0] dx, logic [15:0] dy, logic [15:0] qx,
                               logic [15:0] qy);
      csr_write(mdcr_pkg::REG_DIR_X, dx);
      csr_write(mdcr_pkg::REG_DIR_Y, dy);
      csr_write(mdcr_pkg::REG_PLANE_X, qx);
      csr_write(mdcr_pkg::REG_PLANE_Y, qy);
   endtask

   // ---------------------------------------------------------------- random picks

   function automatic logic signed [15:0] next_pointer();
      int step;
      case ($urandom_range(0, 19))
         0:          return sent_x;
         1:          return 16'h7FFF;
         2:          return 16'h8000;
         3, 4, 5, 6: return 16'($urandom);
         7, 8: begin
            step = int'($urandom_range(0, 4096)) - 2048;
            return sent_x + 16'(step);
         end
         default: begin
            step = int'($urandom_range(0, 64)) - 32;
            return sent_x + 16'(step);
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_sens();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(1, 2000));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_comp();
      case ($urandom_range(0, 5))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // first beat only records; then full-scale jumps both ways and a zero delta
   task automatic test_first_event_and_pointer_extremes();
      send_pointer(16'h8000);
      send_pointer(16'h7FFF);
      send_pointer(16'h8000);
      send_pointer(16'h8000);
      send_pointer(16'h0000);
      send_pointer(16'h0001);
      send_pointer(16'hFFFF);
   endtask

   // angles that wrap to exactly zero, zero sensitivity, and an ignored register
   task automatic test_zero_angle_cases();
      settle();
      csr_write(mdcr_pkg::REG_SENS, 16'h8000);
      csr_write(REG_UNUSED, 16'h1234);
      send_pointer(16'h0000);
      send_pointer(16'h0200);
      send_pointer(16'hFE00);
      send_pointer(16'h0001);
      settle();
      csr_write(mdcr_pkg::REG_SENS, 16'h0000);
      send_pointer(16'h7FFF);
      send_pointer(16'h8000);
   endtask

   // angles at and beyond a quarter turn, exactly half a turn, and the top sensitivity
   task automatic test_fold_beyond_quarter_turn();
      settle();
      csr_write(mdcr_pkg::REG_SENS, 16'd4096);
      send_pointer(16'd0);
      send_pointer(16'd1024);
      send_pointer(16'd3072);
      send_pointer(16'd2048);
      settle();
      csr_write(mdcr_pkg::REG_SENS, 16'hFFFF);
      send_pointer(16'd128);
      send_pointer(16'd28);
      send_pointer(16'd100);
   endtask

   // full-scale start vectors turned by an eighth of a turn must clamp
   task automatic test_saturation();
      settle();
      csr_write(mdcr_pkg::REG_SENS, 16'h8000);
      load_vectors(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
      send_pointer(sent_x + 16'sd64);
      send_pointer(sent_x - 16'sd64);
      settle();
      load_vectors(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_pointer(sent_x - 16'sd64);
   endtask

   // stall the result side for a long stretch while beats keep coming
   task automatic test_result_backpressure();
      settle();
      csr_write(mdcr_pkg::REG_SENS, 16'd8011);
      load_vectors(16'h0000, 16'hC000, 16'd10813, 16'h0000);
      hold_asked++;
      repeat (24) send_pointer(next_pointer());
   endtask

   // random pointer traffic over several register settings; last phase runs flat out
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         gaps_on   = (phase != 5) && (phase % 2 == 0 || phase == 3);
         sink_calm = (phase == 5) || (phase == 2);
         csr_write(mdcr_pkg::REG_SENS, pick_sens());
         load_vectors(pick_comp(), pick_comp(), pick_comp(), pick_comp());
         repeat (250) begin
            send_pointer(next_pointer());
            pointer_gap();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      cam_sens          = 16'd8011;
      cam_last_x        = '0;
      cam_first_pending = 1'b1;
      cam_dir           = '{x: 16'sd0, y: -16'sd16384};
      cam_plane         = '{x: 16'sd10813, y: 16'sd0};
      @(posedge clock);

      test_first_event_and_pointer_extremes();
      test_zero_angle_cases();
      test_fold_beyond_quarter_turn();
      test_saturation();
      test_result_backpressure();
      test_random_traffic();

      // drain and let the tail run out
      req_valid <= 1'b0;
      while (view_q.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
